FILE: design/lfulru_pkg.sv
// shared types and constants for the lfu/lru replacement core
// no dependencies; used by the interfaces, controller, datapath and top level
package lfulru_pkg;

  // fixed field widths of the request and result channels
  localparam int ACTION_W = 2;
  localparam int SET_W    = 6;
  localparam int WAY_W    = 3;
  localparam int VCOUNT_W = 16;

  // default geometry
  localparam int SETS_DEF       = 64;
  localparam int WAYS_DEF       = 8;
  localparam int COUNT_BITS_DEF = 16;
  localparam int STAMP_BITS_DEF = 32;

  // request action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_INVALIDATE = 2'd0,
    ACT_TOUCH      = 2'd1,
    ACT_INSERT     = 2'd2,
    ACT_VICTIM     = 2'd3
  } lfulru_act_t;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_RESULT
  } lfulru_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_we;
    logic in_ready;
    logic accept;
    logic upd_we;
    logic scan_step;
    logic out_load;
  } lfulru_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_valid;
    logic in_victim;
    logic clr_last;
    logic scan_last;
    logic out_free;
  } lfulru_stat_t;

endpackage

FILE: design/lfulru_if.sv
// request and result channel interfaces of the lfu/lru replacement core
// depends on lfulru_pkg for the field widths
interface lfulru_req_if;
  import lfulru_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [SET_W-1:0]    set_index;
  logic [WAY_W-1:0]    way_index;

  modport source (output valid, action, set_index, way_index, input ready);
  modport sink (input valid, action, set_index, way_index, output ready);
endinterface

interface lfulru_res_if;
  import lfulru_pkg::*;

  logic                valid;
  logic                ready;
  logic [WAY_W-1:0]    victim_way;
  logic [VCOUNT_W-1:0] victim_count;

  modport source (output valid, victim_way, victim_count, input ready);
  modport sink (input valid, victim_way, victim_count, output ready);
endinterface

FILE: design/lfulru_ctrl.sv
// controller state machine of the lfu/lru replacement core
// depends on lfulru_pkg; drives the datapath through lfulru_cmd_t
module lfulru_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lfulru_pkg::lfulru_stat_t   stat,
  output lfulru_pkg::lfulru_cmd_t    cmd
);
  import lfulru_pkg::*;

  lfulru_state_t state_r;
  lfulru_state_t state_nxt;

  // state register, clearing pass first after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (stat.in_valid) begin
          state_nxt = stat.in_victim ? ST_SCAN : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
      end
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.accept   = stat.in_valid;
      end
      ST_UPDATE: begin
        cmd.upd_we = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_RESULT: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: design/lfulru_dp.sv
// datapath of the lfu/lru replacement core: set-row memory, update, victim scan
// depends on lfulru_pkg and the channel interfaces in lfulru_if
module lfulru_dp #(
  parameter int SETS       = lfulru_pkg::SETS_DEF,
  parameter int WAYS       = lfulru_pkg::WAYS_DEF,
  parameter int COUNT_BITS = lfulru_pkg::COUNT_BITS_DEF,
  parameter int STAMP_BITS = lfulru_pkg::STAMP_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lfulru_pkg::lfulru_cmd_t  cmd,
  output lfulru_pkg::lfulru_stat_t stat,
  lfulru_req_if.sink               in_req,
  lfulru_res_if.source             out_res
);
  import lfulru_pkg::*;

  localparam int AW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WIW = $clog2(WAYS);

  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt;
    logic [STAMP_BITS-1:0] stamp;
  } ent_t;

  typedef ent_t [WAYS-1:0] row_t;

  // one row per set, all ways side by side
  row_t row_mem [SETS];

  row_t                  rd_row_r;
  row_t                  upd_row_nxt;
  ent_t                  upd_ent;
  ent_t                  scan_ent;
  logic [AW-1:0]         in_addr;
  logic [AW-1:0]         addr_r;
  logic [AW-1:0]         clr_r;
  logic [WIW-1:0]        way_r;
  logic [WIW-1:0]        scan_r;
  logic [ACTION_W-1:0]   act_r;
  logic                  set_ok_r;
  logic                  way_ok_r;
  logic [STAMP_BITS-1:0] stamp_r;
  logic [STAMP_BITS-1:0] stamp_nxt;
  logic                  upd_go;
  logic                  take_best;
  logic [COUNT_BITS-1:0] best_cnt_r;
  logic [STAMP_BITS-1:0] best_stamp_r;
  logic [WIW-1:0]        best_way_r;
  logic                  out_valid_r;
  logic [WAY_W-1:0]      out_way_r;
  logic [VCOUNT_W-1:0]   out_cnt_r;

  assign in_addr = AW'(in_req.set_index);

  // status to the controller
  assign stat.in_valid  = in_req.valid;
  assign stat.in_victim = (in_req.action == ACT_VICTIM);
  assign stat.clr_last  = (clr_r == AW'(SETS - 1));
  assign stat.scan_last = (scan_r == WIW'(WAYS - 1));
  assign stat.out_free  = !out_valid_r || out_res.ready;

  assign in_req.ready = cmd.in_ready;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r    <= in_req.action;
      addr_r   <= in_addr;
      way_r    <= WIW'(in_req.way_index);
      set_ok_r <= (32'(in_req.set_index) < SETS);
      way_ok_r <= (32'(in_req.way_index) < WAYS);
    end
  end

  // update only for an addressed way inside the cache
  assign upd_go = cmd.upd_we && set_ok_r && way_ok_r;

  // saturating global stamp
  assign stamp_nxt = (stamp_r != '1) ? stamp_r + 1'b1 : stamp_r;

  // modified row for invalidate, touch and insert
  always_comb begin
    upd_row_nxt = rd_row_r;
    upd_ent     = rd_row_r[way_r];
    case (act_r)
      ACT_INVALIDATE: begin
        upd_ent = '0;
      end
      ACT_TOUCH: begin
        if (upd_ent.cnt != '1) upd_ent.cnt = upd_ent.cnt + 1'b1;
        upd_ent.stamp = stamp_nxt;
      end
      default: begin
        upd_ent.cnt   = COUNT_BITS'(1);
        upd_ent.stamp = stamp_nxt;
      end
    endcase
    upd_row_nxt[way_r] = upd_ent;
  end

  // row memory: clear sweep or write-back, read on request
  always_ff @(posedge clk) begin
    if (cmd.clr_we) begin
      row_mem[clr_r] <= '0;
    end else if (upd_go) begin
      row_mem[addr_r] <= upd_row_nxt;
    end
    if (cmd.accept) begin
      rd_row_r <= row_mem[in_addr];
    end
  end

  // stamp counter, clear sweep counter and scan counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r <= '0;
      clr_r   <= '0;
      scan_r  <= '0;
    end else begin
      if (upd_go && (act_r != ACT_INVALIDATE)) stamp_r <= stamp_nxt;
      if (cmd.clr_we) clr_r <= stat.clr_last ? '0 : clr_r + 1'b1;
      if (cmd.scan_step) scan_r <= stat.scan_last ? '0 : scan_r + 1'b1;
    end
  end

  // victim scan, one way per cycle
  assign scan_ent  = rd_row_r[scan_r];
  assign take_best = (scan_r == '0) || (scan_ent.cnt < best_cnt_r) ||
                     ((scan_ent.cnt == best_cnt_r) && (scan_ent.stamp < best_stamp_r));

  always_ff @(posedge clk) begin
    if (cmd.scan_step && take_best) begin
      best_cnt_r   <= scan_ent.cnt;
      best_stamp_r <= scan_ent.stamp;
      best_way_r   <= scan_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_way_r <= set_ok_r ? WAY_W'(best_way_r) : '0;
      out_cnt_r <= set_ok_r ? VCOUNT_W'(best_cnt_r) : '0;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.victim_way   = out_way_r;
  assign out_res.victim_count = out_cnt_r;

endmodule

FILE: design/lfu_lru_tiebreak_replacement_core.sv
// Replacement state for a set-associative cache: each way keeps a saturating
// reference count and a last-use stamp from one shared saturating stamp
// counter. Invalidate, touch and insert requests read the set's row, then
// write it back. For a victim query the set's row is read once and one shared
// compare unit walks the ways one per cycle, picking the smallest count, then
// the oldest stamp, then the lowest way. A new request is taken while an
// earlier result still waits on the result channel. After reset a clearing
// pass zeroes the row memory; no request is taken during it.
module lfu_lru_tiebreak_replacement_core #(
  parameter int SETS       = lfulru_pkg::SETS_DEF,
  parameter int WAYS       = lfulru_pkg::WAYS_DEF,
  parameter int COUNT_BITS = lfulru_pkg::COUNT_BITS_DEF,
  parameter int STAMP_BITS = lfulru_pkg::STAMP_BITS_DEF
) (
  input logic          clk,
  input logic          rst_n,
  lfulru_req_if.sink   in_req,
  lfulru_res_if.source out_res
);
  import lfulru_pkg::*;

  lfulru_cmd_t  cmd;
  lfulru_stat_t stat;

  // sequencing
  lfulru_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // storage, update and victim search
  lfulru_dp #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .COUNT_BITS (COUNT_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .stat    (stat),
    .in_req  (in_req),
    .out_res (out_res)
  );

endmodule
